// ===== rtl/stack_push_remove_by_value_unit_macros.svh =====
// Assertion macros for the stack push/remove-by-value unit.
// Each macro checks an implication on the rising edge of i_clk, disabled in reset.
`ifndef STACK_PUSH_REMOVE_BY_VALUE_UNIT_MACROS_SVH
`define STACK_PUSH_REMOVE_BY_VALUE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPR_ASSERT_SAME(label, ante, cons, msg)
`define SPR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Types and constants shared by the stack push/remove-by-value unit.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        OP_PUSH   = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_res;

endpackage

// ===== rtl/spr_if.sv =====
// ----------------------------------------------------------------------------
// spr_if
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface spr_req_if import spr_pkg::*;;
    logic               valid;
    logic               ready;
    t_op                opcode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface spr_rsp_if import spr_pkg::*;;
    logic               valid;
    logic               ready;
    t_status            status;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface

interface spr_cfg_if import spr_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ===== rtl/spr_ram.sv =====
// ----------------------------------------------------------------------------
// spr_ram
// Stack storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spr_ram import spr_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spr_ctrl.sv =====
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer with one shared comparator: searches the stack top down one entry
// per cycle, then closes the gap one entry per cycle.
// ----------------------------------------------------------------------------
module spr_ctrl import spr_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spr_req_if.sink           i_req,
    input  logic [CAP_W-1:0]  i_capacity,
    output t_res              o_res,
    input  logic              i_res_ack,
    output logic [CW-1:0]     o_count,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [DATA_W-1:0] o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [DATA_W-1:0] i_mem_rdata
);

    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [DATA_W-1:0] r_value, n_value;
    t_status           r_status, n_status;
    logic              w_full;

    assign w_full = (CMP_W'(r_count) >= CMP_W'(i_capacity)) || (r_count >= CW'(DEPTH));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_value     = r_value;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_value = i_req.value;
                    if (i_req.opcode == OP_PUSH) begin
                        n_state = S_RESP;
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_count);
                            o_mem_wdata = i_req.value;
                            n_count     = r_count + CW'(1);
                            n_status    = ST_DONE;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_RESP;
                    end else begin
                        // Start the search at the top entry.
                        n_ptr       = AW'(r_count - CW'(1));
                        o_mem_raddr = n_ptr;
                        n_state     = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // The read data belongs to the entry at r_ptr.
                if (i_mem_rdata == r_value) begin
                    if (CW'(r_ptr) + CW'(1) == r_count) begin
                        n_count  = r_count - CW'(1);
                        n_status = ST_DONE;
                        n_state  = S_RESP;
                    end else begin
                        o_mem_raddr = r_ptr + AW'(1);
                        n_state     = S_SHIFT;
                    end
                end else if (r_ptr == '0) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_ptr       = r_ptr - AW'(1);
                    o_mem_raddr = n_ptr;
                end
            end
            S_SHIFT: begin
                // Move the entry above r_ptr down into r_ptr.
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr;
                o_mem_wdata = i_mem_rdata;
                if (CW'(r_ptr) + CW'(2) == r_count) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_DONE;
                    n_state  = S_RESP;
                end else begin
                    n_ptr       = r_ptr + AW'(1);
                    o_mem_raddr = r_ptr + AW'(2);
                end
            end
            S_RESP: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_ptr    <= n_ptr;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_RESP);
    assign o_res.status = r_status;
    assign o_res.count  = COUNT_W'(r_count);
    assign o_count      = r_count;

endmodule

// ===== rtl/stack_push_remove_by_value_unit.sv =====
// Push: the sequencer registers the request and enters its response state; from there the
// response word moves to the output register when that register is empty or being drained,
// and the next request can be accepted after that move. Remove: first s entries are compared
// top down and m entries move down one place, one entry per cycle; the response then follows.
// One request is in work at a time; the next is taken while a response word waits.
// Synchronous active-low reset clears the count, the capacity (to 16) and all handshake state;
// stack memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// stack_push_remove_by_value_unit
// Bounded LIFO stack with push and remove-by-value requests.
// ----------------------------------------------------------------------------
`include "stack_push_remove_by_value_unit_macros.svh"

module stack_push_remove_by_value_unit import spr_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spr_cfg_if.sink   i_cfg,
    spr_req_if.sink   i_req,
    spr_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0]  r_capacity;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    t_res              w_res;
    logic              w_res_ack;
    logic [CW-1:0]     w_count;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [DATA_W-1:0] w_mem_wdata;
    logic [AW-1:0]     w_mem_raddr;
    logic [DATA_W-1:0] w_mem_rdata;

    // The capacity register is always ready for a write.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.capacity;
        end
    end

    // The output register takes a response when it is empty or being drained.
    assign w_res_ack = w_res.valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_ack) begin
            r_out_status <= w_res.status;
            r_out_count  <= w_res.count;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.count  = r_out_count;

    spr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_capacity  (r_capacity),
        .o_res       (w_res),
        .i_res_ack   (w_res_ack),
        .o_count     (w_count),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    spr_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    `SPR_ASSERT_SAME(a_count_bound, 1'b1, w_count <= CW'(DEPTH), "entry count above depth")
    `SPR_ASSERT_SAME(a_accept_no_pending, i_req.valid && i_req.ready, !w_res.valid, "busy take")
    `SPR_ASSERT_NEXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready, "ready high")

endmodule
